// File: rtl/oadc_pkg.sv
// Package for the obstacle-avoiding drive controller: field widths, codes,
// beat and state structs shared by the channel interfaces and the RTL.
// No dependencies.
package oadc_pkg;

  localparam int TIMER_BITS = 16;
  localparam int LIMIT_W    = 16;
  localparam int CMP_W      = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;
  localparam int DIST_W     = 10;
  localparam int CMD_W      = 4;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_CM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKUP_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_TICKS   = 2'd2;

  localparam logic [DIST_W-1:0]  OBSTACLE_RST = 10'd25;
  localparam logic [LIMIT_W-1:0] BACKUP_RST   = 16'd150;
  localparam logic [LIMIT_W-1:0] TURN_RST     = 16'd250;

  // Command codes; anything above CMD_AUTO is ignored.
  localparam logic [CMD_W-1:0] CMD_HALT      = 4'd0;
  localparam logic [CMD_W-1:0] CMD_FWD       = 4'd1;
  localparam logic [CMD_W-1:0] CMD_BACK      = 4'd2;
  localparam logic [CMD_W-1:0] CMD_TURN_L    = 4'd3;
  localparam logic [CMD_W-1:0] CMD_TURN_R    = 4'd4;
  localparam logic [CMD_W-1:0] CMD_SPEED_HI  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_SPEED_MID = 4'd6;
  localparam logic [CMD_W-1:0] CMD_SPEED_LO  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_VACUUM    = 4'd8;
  localparam logic [CMD_W-1:0] CMD_AUTO      = 4'd9;

  localparam logic KIND_COMMAND = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  typedef enum logic [1:0] {
    MODE_HAND   = 2'd0,
    MODE_FWD    = 2'd1,
    MODE_BACKUP = 2'd2,
    MODE_TURN   = 2'd3
  } drive_mode_t;

  localparam logic [2:0] DIR_NONE  = 3'd0;
  localparam logic [2:0] DIR_FWD   = 3'd1;
  localparam logic [2:0] DIR_BACK  = 3'd2;
  localparam logic [2:0] DIR_LEFT  = 3'd3;
  localparam logic [2:0] DIR_RIGHT = 3'd4;

  localparam logic [2:0] SPD_NONE   = 3'd0;
  localparam logic [2:0] SPD_STOP   = 3'd1;
  localparam logic [2:0] SPD_SLOW   = 3'd2;
  localparam logic [2:0] SPD_MEDIUM = 3'd3;
  localparam logic [2:0] SPD_FAST   = 3'd4;
  localparam logic [2:0] SPD_LDIFF  = 3'd5;
  localparam logic [2:0] SPD_RDIFF  = 3'd6;

  localparam logic [1:0] VAC_NONE = 2'd0;
  localparam logic [1:0] VAC_ON   = 2'd1;
  localparam logic [1:0] VAC_OFF  = 2'd2;

  typedef struct packed {
    logic              mode;
    logic [CMD_W-1:0]  command;
    logic              distance_valid;
    logic [DIST_W-1:0] distance_cm;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] robot_mode;
    logic [2:0] direction;
    logic [2:0] speed_action;
    logic [1:0] vacuum_action;
  } out_beat_t;

  typedef struct packed {
    logic [DIST_W-1:0]  obstacle_cm;
    logic [LIMIT_W-1:0] backup_ticks;
    logic [LIMIT_W-1:0] turn_ticks;
  } cfg_regs_t;

  typedef struct packed {
    drive_mode_t           mode;
    logic [TIMER_BITS-1:0] count;
  } drive_state_t;

endpackage

// File: rtl/oadc_chan_if.sv
// Valid/ready channel interfaces for the drive controller's input and result
// beats. Depends on oadc_pkg.
interface oadc_in_if import oadc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CMD_W-1:0]  command;
  logic              distance_valid;
  logic [DIST_W-1:0] distance_cm;

  modport source (output valid, mode, command, distance_valid, distance_cm, input ready);
  modport sink   (input valid, mode, command, distance_valid, distance_cm, output ready);
endinterface

interface oadc_out_if import oadc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] robot_mode;
  logic [2:0] direction;
  logic [2:0] speed_action;
  logic [1:0] vacuum_action;

  modport source (output valid, robot_mode, direction, speed_action, vacuum_action,
                  input ready);
  modport sink   (input valid, robot_mode, direction, speed_action, vacuum_action,
                  output ready);
endinterface

// File: rtl/oadc_step.sv
// Next-state and action logic for one beat of the drive controller.
// Purely combinational; depends on oadc_pkg.
module oadc_step import oadc_pkg::*; (
  input  in_beat_t     beat,
  input  drive_state_t state,
  input  cfg_regs_t    cfg,
  output drive_state_t state_nxt,
  output out_beat_t    res
);

  localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

  logic [TIMER_BITS-1:0] cnt_inc;
  logic                  cnt_sat;
  logic [LIMIT_W-1:0]    limit;
  logic                  phase_end;
  logic [2:0]            dir;
  logic [2:0]            spd;
  logic [1:0]            vac;

  // The counter saturates; a saturated count ends the phase whatever the limit.
  assign cnt_sat   = (state.count == CNT_MAX);
  assign cnt_inc   = cnt_sat ? state.count : state.count + 1'b1;
  assign limit     = (state.mode == MODE_BACKUP) ? cfg.backup_ticks : cfg.turn_ticks;
  assign phase_end = (CMP_W'(cnt_inc) >= CMP_W'(limit)) || (cnt_inc == CNT_MAX);

  always_comb begin
    state_nxt = state;
    dir       = DIR_NONE;
    spd       = SPD_NONE;
    vac       = VAC_NONE;
    if (beat.mode == KIND_COMMAND) begin
      case (beat.command)
        CMD_HALT: begin
          state_nxt.mode = MODE_HAND;
          spd = SPD_STOP;
          vac = VAC_OFF;
        end
        CMD_FWD: begin
          state_nxt.mode = MODE_HAND;
          dir = DIR_FWD;
        end
        CMD_BACK: begin
          state_nxt.mode = MODE_HAND;
          dir = DIR_BACK;
        end
        CMD_TURN_L: begin
          state_nxt.mode = MODE_HAND;
          dir = DIR_LEFT;
          spd = SPD_LDIFF;
        end
        CMD_TURN_R: begin
          state_nxt.mode = MODE_HAND;
          dir = DIR_RIGHT;
          spd = SPD_RDIFF;
        end
        CMD_SPEED_HI: begin
          state_nxt.mode = MODE_HAND;
          spd = SPD_FAST;
        end
        CMD_SPEED_MID: begin
          state_nxt.mode = MODE_HAND;
          spd = SPD_MEDIUM;
        end
        CMD_SPEED_LO: begin
          state_nxt.mode = MODE_HAND;
          spd = SPD_SLOW;
        end
        CMD_VACUUM: begin
          state_nxt.mode = MODE_HAND;
          vac = VAC_ON;
        end
        CMD_AUTO: begin
          state_nxt.mode  = MODE_FWD;
          state_nxt.count = '0;
          dir = DIR_FWD;
          spd = SPD_MEDIUM;
          vac = VAC_ON;
        end
        default: begin
        end
      endcase
    end else begin
      case (state.mode)
        MODE_FWD: begin
          if (beat.distance_valid && (beat.distance_cm <= cfg.obstacle_cm)) begin
            state_nxt.mode  = MODE_BACKUP;
            state_nxt.count = '0;
            dir = DIR_BACK;
            spd = SPD_FAST;
          end
        end
        MODE_BACKUP: begin
          state_nxt.count = cnt_inc;
          if (phase_end) begin
            state_nxt.mode  = MODE_TURN;
            state_nxt.count = '0;
            dir = DIR_LEFT;
            spd = SPD_LDIFF;
          end
        end
        MODE_TURN: begin
          state_nxt.count = cnt_inc;
          if (phase_end) begin
            state_nxt.mode  = MODE_FWD;
            state_nxt.count = '0;
            dir = DIR_FWD;
            spd = SPD_MEDIUM;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res.robot_mode    = state_nxt.mode;
  assign res.direction     = dir;
  assign res.speed_action  = spd;
  assign res.vacuum_action = vac;

endmodule

// File: rtl/obstacle_avoid_drive_controller_unit.sv
// Top level of the obstacle-avoiding drive controller: input register, step
// logic and result register. Depends on oadc_pkg, oadc_chan_if and oadc_step.
//
//   port     direction  handshake         payload
//   in_ch    sink       valid / ready     mode, command, distance_valid, distance_cm
//   out_ch   source     valid / ready     robot_mode, direction, speed_action,
//                                         vacuum_action
//   cfg_*    sink       cfg_we only       cfg_index, cfg_wdata
//
// One beat is accepted per cycle while in_ch.ready is high; its result passes
// through the input register, then the result register, before it leaves on out_ch.
// Drive state and the result register update on the same edge, so the next
// beat in the input register always sees the state its predecessor left.
// A stalled result holds the input register, and in_ch.ready drops only when
// both registers are full. Reset is synchronous.
module obstacle_avoid_drive_controller_unit import oadc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  oadc_in_if.sink               in_ch,
  oadc_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_regs_t    cfg_r;
  drive_state_t state_r;
  drive_state_t state_nxt;
  in_beat_t     beat_r;
  in_beat_t     beat_in;
  logic         beat_valid_r;
  out_beat_t    res_r;
  out_beat_t    res_nxt;
  logic         res_valid_r;
  logic         res_take;
  logic         in_take;

  assign res_take = !res_valid_r || out_ch.ready;
  assign in_take  = !beat_valid_r || res_take;

  assign in_ch.ready = in_take;

  assign beat_in.mode           = in_ch.mode;
  assign beat_in.command        = in_ch.command;
  assign beat_in.distance_valid = in_ch.distance_valid;
  assign beat_in.distance_cm    = in_ch.distance_cm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.obstacle_cm  <= OBSTACLE_RST;
      cfg_r.backup_ticks <= BACKUP_RST;
      cfg_r.turn_ticks   <= TURN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OBSTACLE_CM:  cfg_r.obstacle_cm  <= cfg_wdata[DIST_W-1:0];
        REG_BACKUP_TICKS: cfg_r.backup_ticks <= cfg_wdata[LIMIT_W-1:0];
        REG_TURN_TICKS:   cfg_r.turn_ticks   <= cfg_wdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  oadc_step u_step (
    .beat      (beat_r),
    .state     (state_r),
    .cfg       (cfg_r),
    .state_nxt (state_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_valid_r  <= 1'b0;
      res_valid_r   <= 1'b0;
      state_r.mode  <= MODE_HAND;
      state_r.count <= '0;
    end else begin
      if (in_take) begin
        beat_valid_r <= in_ch.valid;
      end
      if (res_take) begin
        res_valid_r <= beat_valid_r;
        if (beat_valid_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_ch.valid) begin
      beat_r <= beat_in;
    end
    if (res_take && beat_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = res_valid_r;
  assign out_ch.robot_mode    = res_r.robot_mode;
  assign out_ch.direction     = res_r.direction;
  assign out_ch.speed_action  = res_r.speed_action;
  assign out_ch.vacuum_action = res_r.vacuum_action;

  // Forward driving is only ever entered with a cleared phase counter.
  a_fwd_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.mode == MODE_FWD |-> state_r.count == '0)
    else $error("phase counter not clear in forward mode");

  // A beat held behind a stalled result must not move the drive state.
  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_valid_r && !res_take) |=> $stable(state_r))
    else $error("drive state moved during a result stall");

  // The reported mode is the state the beat left behind.
  a_mode_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_valid_r && res_take) |=> res_r.robot_mode == state_r.mode)
    else $error("result mode differs from drive state");

endmodule
